>>> rtl/core/qbsp_pkg.sv
`timescale 1ns / 1ps

package qbsp_pkg;

    localparam int KNOT_W    = 17;
    localparam int COORD_W   = 32;
    localparam int NUM_KNOTS = 6;
    localparam int CFG_IDX_W = 3;

    localparam logic [KNOT_W-1:0] PARAM_ONE = 17'h10000;

    localparam logic [NUM_KNOTS-1:0][KNOT_W-1:0] KNOT_RST = {
        17'h10000, 17'h10000, 17'h10000, 17'h00000, 17'h00000, 17'h00000
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KNOT_ZERO  = 3'd0,
        CFG_KNOT_ONE   = 3'd1,
        CFG_KNOT_TWO   = 3'd2,
        CFG_KNOT_THREE = 3'd3,
        CFG_KNOT_FOUR  = 3'd4,
        CFG_KNOT_FIVE  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [KNOT_W-1:0]         param_u;
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] az;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
        logic signed [COORD_W-1:0] bz;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
    } t_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
        logic                      saturated;
    } t_result;

endpackage

>>> rtl/core/qbsp_udiv.sv
`timescale 1ns / 1ps

// The divisor must hold steady while any dividend is in flight.
module qbsp_udiv #(
    parameter int NUM_W = 33,
    parameter int DEN_W = 17
) (
    input  logic             i_clk,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo
);

    logic [DEN_W-1:0] r_rem [NUM_W];
    logic [NUM_W-1:0] r_num [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [DEN_W-1:0] w_rem_in;
        logic [NUM_W-1:0] w_num_in;
        logic [DEN_W:0]   w_try;
        logic [DEN_W-1:0] n_rem;
        logic [NUM_W-1:0] n_num;

        if (k == 0) begin : g_first
            assign w_rem_in = '0;
            assign w_num_in = i_num;
        end else begin : g_next
            assign w_rem_in = r_rem[k-1];
            assign w_num_in = r_num[k-1];
        end

        always_comb begin
            w_try = {w_rem_in, w_num_in[NUM_W-1]};
            if (w_try >= {1'b0, i_den}) begin
                n_rem = DEN_W'(w_try - {1'b0, i_den});
                n_num = {w_num_in[NUM_W-2:0], 1'b1};
            end else begin
                n_rem = w_try[DEN_W-1:0];
                n_num = {w_num_in[NUM_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= n_rem;
            r_num[k] <= n_num;
        end
    end

    assign o_quo = r_num[NUM_W-1];

endmodule

>>> rtl/core/qbsp_delay.sv
`timescale 1ns / 1ps

module qbsp_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_vld,
    input  logic [W-1:0] i_dat,
    output logic         o_vld,
    output logic [W-1:0] o_dat
);

    logic         r_vld [DEPTH];
    logic [W-1:0] r_dat [DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[0] <= i_vld;
            for (int k = DEPTH - 1; k > 0; k--) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dat[0] <= i_dat;
        for (int k = DEPTH - 1; k > 0; k--) begin
            r_dat[k] <= r_dat[k-1];
        end
    end

    assign o_vld = r_vld[DEPTH-1];
    assign o_dat = r_dat[DEPTH-1];

endmodule

>>> rtl/core/qbsp_blend.sv
`timescale 1ns / 1ps

module qbsp_blend import qbsp_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_vld,
    input  logic [2:0][FRAC_BITS+2:0]            i_basis,
    input  logic                                 i_sat,
    input  t_item                                i_item,
    output logic                                 o_vld,
    output t_result                              o_result
);

    localparam int N2_W   = FRAC_BITS + 3;
    localparam int PROD_W = N2_W + COORD_W;
    localparam int RND_W  = PROD_W - FRAC_BITS;
    localparam int ACC_W  = RND_W + 2;

    localparam logic signed [PROD_W-1:0] HALF    = PROD_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0]  OUT_MAX = ACC_W'(33'sh0_7FFF_FFFF);
    localparam logic signed [ACC_W-1:0]  OUT_MIN = -ACC_W'(33'sh0_8000_0000);

    logic signed [COORD_W-1:0] w_pt [3][3];

    logic                     r4_vld, r5_vld, r_vld;
    logic                     r4_sat, r5_sat;
    logic signed [PROD_W-1:0] r4_prod [3][3];
    logic signed [RND_W-1:0]  r5_rnd  [3][3];
    t_result                  r_result;

    logic signed [ACC_W-1:0]  w_sum [3];
    logic signed [COORD_W-1:0] n_coord [3];
    logic                     n_sat;

    always_comb begin
        w_pt[0][0] = i_item.ax; w_pt[0][1] = i_item.ay; w_pt[0][2] = i_item.az;
        w_pt[1][0] = i_item.bx; w_pt[1][1] = i_item.by; w_pt[1][2] = i_item.bz;
        w_pt[2][0] = i_item.cx; w_pt[2][1] = i_item.cy; w_pt[2][2] = i_item.cz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r_vld  <= 1'b0;
        end else begin
            r4_vld <= i_vld;
            r5_vld <= r4_vld;
            r_vld  <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_sat <= i_sat;
        r5_sat <= r4_sat;
        for (int i = 0; i < 3; i++) begin
            for (int c = 0; c < 3; c++) begin
                r4_prod[i][c] <= $signed(i_basis[i]) * w_pt[i][c];
                r5_rnd[i][c]  <= RND_W'((r4_prod[i][c] + HALF) >>> FRAC_BITS);
            end
        end
    end

    always_comb begin
        n_sat = r5_sat;
        for (int c = 0; c < 3; c++) begin
            w_sum[c] = ACC_W'(r5_rnd[0][c]) + ACC_W'(r5_rnd[1][c]) + ACC_W'(r5_rnd[2][c]);
            if (w_sum[c] > OUT_MAX) begin
                n_coord[c] = OUT_MAX[COORD_W-1:0];
                n_sat      = 1'b1;
            end else if (w_sum[c] < OUT_MIN) begin
                n_coord[c] = OUT_MIN[COORD_W-1:0];
                n_sat      = 1'b1;
            end else begin
                n_coord[c] = w_sum[c][COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_result.px        <= n_coord[0];
        r_result.py        <= n_coord[1];
        r_result.pz        <= n_coord[2];
        r_result.saturated <= n_sat;
    end

    assign o_vld    = r_vld;
    assign o_result = r_result;

endmodule

>>> rtl/core/quadratic_bspline_point_eval.sv
`timescale 1ns / 1ps

// Channel    Handshake           Payload          Direction
// item       start / busy        i_item           in
// result     o_valid             o_result         out
// config     i_cfg_we            i_cfg_idx/data   in
//
// A new item transfer can be taken in every cycle; busy is high only in the cycle after reset.
// An item travels from its transfer to o_valid through the input register, the two
// bit-per-stage divider chains (degree one and degree two) and the blend stages.
// Reset is synchronous and clears the knots to their defaults and all valid bits.
// The receiver cannot stall, so each result is shown for exactly one cycle.
module quadratic_bspline_point_eval import qbsp_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_item                i_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [KNOT_W-1:0]    i_cfg_data,
    output logic                 o_valid,
    output t_result              o_result
);

    localparam int D1_NW   = KNOT_W + FRAC_BITS;
    localparam int B_W     = FRAC_BITS + 1;
    localparam int D2_NW   = B_W + KNOT_W;
    localparam int Q2S_W   = D2_NW + 1;
    localparam int SUM2_W  = D2_NW + 2;
    localparam int N2_W    = FRAC_BITS + 3;
    localparam int ITEM_W  = $bits(t_item);
    localparam int SB1_W   = 5 + ITEM_W;
    localparam int SB2_W   = 6 + ITEM_W;

    localparam logic signed [SUM2_W-1:0] BASIS_LIM = SUM2_W'(1) << (FRAC_BITS + 1);
    localparam logic [N2_W-1:0]          BASIS_ONE = N2_W'(1) << FRAC_BITS;

    logic [KNOT_W-1:0] r_knot [NUM_KNOTS];
    logic              r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_KNOTS; k++) begin
                r_knot[k] <= KNOT_RST[k];
            end
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_KNOT_ZERO:  r_knot[0] <= i_cfg_data;
                    CFG_KNOT_ONE:   r_knot[1] <= i_cfg_data;
                    CFG_KNOT_TWO:   r_knot[2] <= i_cfg_data;
                    CFG_KNOT_THREE: r_knot[3] <= i_cfg_data;
                    CFG_KNOT_FOUR:  r_knot[4] <= i_cfg_data;
                    CFG_KNOT_FIVE:  r_knot[5] <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign busy = r_busy;

    logic  r0_vld;
    t_item r0_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else begin
            r0_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_item <= i_item;
    end

    logic [4:0]        w_n0;
    logic [D1_NW-1:0]  w_d1a_num [4];
    logic [D1_NW-1:0]  w_d1b_num [4];
    logic [KNOT_W-1:0] w_d1a_den [4];
    logic [KNOT_W-1:0] w_d1b_den [4];
    logic [D1_NW-1:0]  w_q1a [4];
    logic [D1_NW-1:0]  w_q1b [4];

    always_comb begin
        for (int i = 0; i < 5; i++) begin
            w_n0[i] = (r_knot[i] <= r0_item.param_u) && (r0_item.param_u < r_knot[i+1]);
        end
        for (int i = 0; i < 4; i++) begin
            w_d1a_num[i] = {KNOT_W'(r0_item.param_u - r_knot[i]), {FRAC_BITS{1'b0}}};
            w_d1a_den[i] = KNOT_W'(r_knot[i+1] - r_knot[i]);
            w_d1b_num[i] = {KNOT_W'(r_knot[i+2] - r0_item.param_u), {FRAC_BITS{1'b0}}};
            w_d1b_den[i] = KNOT_W'(r_knot[i+2] - r_knot[i+1]);
        end
    end

    for (genvar i = 0; i < 4; i++) begin : g_deg1
        qbsp_udiv #(.NUM_W(D1_NW), .DEN_W(KNOT_W)) u_div_a (
            .i_clk (i_clk),
            .i_num (w_d1a_num[i]),
            .i_den (w_d1a_den[i]),
            .o_quo (w_q1a[i])
        );
        qbsp_udiv #(.NUM_W(D1_NW), .DEN_W(KNOT_W)) u_div_b (
            .i_clk (i_clk),
            .i_num (w_d1b_num[i]),
            .i_den (w_d1b_den[i]),
            .o_quo (w_q1b[i])
        );
    end

    logic             w1_vld;
    logic [SB1_W-1:0] w1_sb;
    logic [4:0]       w1_n0;
    t_item            w1_item;

    qbsp_delay #(.W(SB1_W), .DEPTH(D1_NW)) u_sb1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r0_vld),
        .i_dat   ({w_n0, r0_item}),
        .o_vld   (w1_vld),
        .o_dat   (w1_sb)
    );

    assign w1_n0   = w1_sb[SB1_W-1 -: 5];
    assign w1_item = t_item'(w1_sb[ITEM_W-1:0]);

    logic [B_W-1:0]    w_n1 [4];
    logic [KNOT_W:0]   w_da [3];
    logic [KNOT_W:0]   w_db [3];
    logic [KNOT_W-1:0] w_ma [3];
    logic [KNOT_W-1:0] w_mb [3];
    logic [D2_NW-1:0]  n2_pa [3];
    logic [D2_NW-1:0]  n2_pb [3];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_n1[i] = (w1_n0[i] ? w_q1a[i][B_W-1:0] : '0)
                    + (w1_n0[i+1] ? w_q1b[i][B_W-1:0] : '0);
        end
        for (int i = 0; i < 3; i++) begin
            w_da[i]  = {1'b0, w1_item.param_u} - {1'b0, r_knot[i]};
            w_db[i]  = {1'b0, r_knot[i+3]} - {1'b0, w1_item.param_u};
            w_ma[i]  = w_da[i][KNOT_W] ? KNOT_W'(-w_da[i]) : w_da[i][KNOT_W-1:0];
            w_mb[i]  = w_db[i][KNOT_W] ? KNOT_W'(-w_db[i]) : w_db[i][KNOT_W-1:0];
            n2_pa[i] = D2_NW'(w_n1[i]) * D2_NW'(w_ma[i]);
            n2_pb[i] = D2_NW'(w_n1[i+1]) * D2_NW'(w_mb[i]);
        end
    end

    logic             r2_vld;
    logic [D2_NW-1:0] r2_pa [3];
    logic [D2_NW-1:0] r2_pb [3];
    logic [2:0]       r2_sa, r2_sb;
    t_item            r2_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= w1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r2_pa[i] <= n2_pa[i];
            r2_pb[i] <= n2_pb[i];
            r2_sa[i] <= w_da[i][KNOT_W];
            r2_sb[i] <= w_db[i][KNOT_W];
        end
        r2_item <= w1_item;
    end

    logic [KNOT_W:0]   w_ea [3];
    logic [KNOT_W:0]   w_eb [3];
    logic [KNOT_W-1:0] w_ema [3];
    logic [KNOT_W-1:0] w_emb [3];
    logic [D2_NW-1:0]  w_q2a [3];
    logic [D2_NW-1:0]  w_q2b [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_ea[i]  = {1'b0, r_knot[i+2]} - {1'b0, r_knot[i]};
            w_eb[i]  = {1'b0, r_knot[i+3]} - {1'b0, r_knot[i+1]};
            w_ema[i] = w_ea[i][KNOT_W] ? KNOT_W'(-w_ea[i]) : w_ea[i][KNOT_W-1:0];
            w_emb[i] = w_eb[i][KNOT_W] ? KNOT_W'(-w_eb[i]) : w_eb[i][KNOT_W-1:0];
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_deg2
        qbsp_udiv #(.NUM_W(D2_NW), .DEN_W(KNOT_W)) u_div_a (
            .i_clk (i_clk),
            .i_num (r2_pa[i]),
            .i_den (w_ema[i]),
            .o_quo (w_q2a[i])
        );
        qbsp_udiv #(.NUM_W(D2_NW), .DEN_W(KNOT_W)) u_div_b (
            .i_clk (i_clk),
            .i_num (r2_pb[i]),
            .i_den (w_emb[i]),
            .o_quo (w_q2b[i])
        );
    end

    logic             w2_vld;
    logic [SB2_W-1:0] w2_sb;
    logic [2:0]       w2_sa, w2_sb_sign;
    t_item            w2_item;

    qbsp_delay #(.W(SB2_W), .DEPTH(D2_NW)) u_sb2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r2_vld),
        .i_dat   ({r2_sa, r2_sb, r2_item}),
        .o_vld   (w2_vld),
        .o_dat   (w2_sb)
    );

    assign w2_sa      = w2_sb[SB2_W-1 -: 3];
    assign w2_sb_sign = w2_sb[SB2_W-4 -: 3];
    assign w2_item    = t_item'(w2_sb[ITEM_W-1:0]);

    logic signed [Q2S_W-1:0]  w_va [3];
    logic signed [Q2S_W-1:0]  w_vb [3];
    logic signed [SUM2_W-1:0] w_s  [3];
    logic [2:0][N2_W-1:0]     n3_n2;
    logic                     n3_sat;

    always_comb begin
        n3_sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (w_ema[i] == '0) begin
                w_va[i] = '0;
            end else if (w2_sa[i] ^ w_ea[i][KNOT_W]) begin
                w_va[i] = -$signed({1'b0, w_q2a[i]});
            end else begin
                w_va[i] = $signed({1'b0, w_q2a[i]});
            end
            if (w_emb[i] == '0) begin
                w_vb[i] = '0;
            end else if (w2_sb_sign[i] ^ w_eb[i][KNOT_W]) begin
                w_vb[i] = -$signed({1'b0, w_q2b[i]});
            end else begin
                w_vb[i] = $signed({1'b0, w_q2b[i]});
            end
            w_s[i] = SUM2_W'(w_va[i]) + SUM2_W'(w_vb[i]);
            if (w_s[i] > BASIS_LIM) begin
                n3_n2[i] = BASIS_LIM[N2_W-1:0];
                n3_sat   = 1'b1;
            end else if (w_s[i] < -BASIS_LIM) begin
                n3_n2[i] = N2_W'(-BASIS_LIM);
                n3_sat   = 1'b1;
            end else begin
                n3_n2[i] = w_s[i][N2_W-1:0];
            end
        end
        if (w2_item.param_u == PARAM_ONE) begin
            n3_n2  = {BASIS_ONE, {N2_W{1'b0}}, {N2_W{1'b0}}};
            n3_sat = 1'b0;
        end
    end

    logic                 r3_vld;
    logic [2:0][N2_W-1:0] r3_n2;
    logic                 r3_sat;
    t_item                r3_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= w2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_n2   <= n3_n2;
        r3_sat  <= n3_sat;
        r3_item <= w2_item;
    end

    qbsp_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (r3_vld),
        .i_basis  (r3_n2),
        .i_sat    (r3_sat),
        .i_item   (r3_item),
        .o_vld    (o_valid),
        .o_result (o_result)
    );

endmodule

>>> rtl/core/qbsp_checker.sv
`timescale 1ns / 1ps

module qbsp_checker import qbsp_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input t_item                i_item,
    input logic                 i_cfg_we,
    input logic [CFG_IDX_W-1:0] i_cfg_idx,
    input logic [KNOT_W-1:0]    i_cfg_data,
    input logic                 o_valid,
    input t_result              o_result
);

    localparam int LAT = 2 * FRAC_BITS + 41;

    // Every result traces back to an item transfer a fixed latency earlier.
    a_result_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result without matching item transfer");

    // At parameter one the result is the third control point, unclipped.
    a_param_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_item.param_u == PARAM_ONE, LAT)) |->
        (o_result.px == $past(i_item.cx, LAT) && o_result.py == $past(i_item.cy, LAT)
         && o_result.pz == $past(i_item.cz, LAT) && !o_result.saturated))
        else $error("parameter one does not return third control point");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result shown right after reset");

    // Busy lasts only for the first cycle out of reset.
    a_busy_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !busy)
        else $error("busy high after the first cycle out of reset");

endmodule

bind quadratic_bspline_point_eval qbsp_checker #(.FRAC_BITS(FRAC_BITS)) u_qbsp_checker (.*);
